@@ sv/rcg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcg_pkg: shared types and constants for the roberts cross gradient block
// pixel and gradient beat formats, config register codes, square root sizing
// ----------------------------------------------------------------------------
package rcg_pkg;

    // line buffer depth and addressing
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = ADDR_W + 1;

    // pixel layout
    localparam int CH_N  = 3;
    localparam int CH_W  = 8;
    localparam int PIX_W = CH_N * CH_W;

    // config port
    localparam int LW_W      = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = LW_W;
    localparam int CMP_W     = (LW_W > CNT_W) ? LW_W : CNT_W;

    // square root sizing: sum of two squared 8-bit differences
    localparam int SUM_W  = 2 * CH_W + 1;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int GRAD_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE = 1'b0,
        CFG_LINE_WIDTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic            frame_start;
        logic [CH_W-1:0] chan0;
        logic [CH_W-1:0] chan1;
        logic [CH_W-1:0] chan2;
    } pix_beat_t;

    typedef struct packed {
        logic [GRAD_W-1:0] grad0;
        logic [GRAD_W-1:0] grad1;
        logic [GRAD_W-1:0] grad2;
    } grad_beat_t;

    // one channel of the digit-by-digit square root
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_lane_t;

    typedef struct packed {
        logic                   color;
        sq_lane_t [CH_N-1:0]    lane;
    } sq_beat_t;

    localparam int SQ_BEAT_W = $bits(sq_beat_t);

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        logic [CH_W-1:0] r;
        if (a >= b)
            r = a - b;
        else
            r = b - a;
        return r;
    endfunction

endpackage

@@ sv/rcg_ram.sv @@
// ----------------------------------------------------------------------------
// rcg_ram: generic single write port, single read port ram
// read data registered, read before write on a shared address
// ----------------------------------------------------------------------------
module rcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/rcg_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rcg_sqrt_cell: one root digit of the restoring square root
// takes two radicand bits per lane, keeps one beat, passes it on
// ----------------------------------------------------------------------------
module rcg_sqrt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rcg_pkg::sq_beat_t in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output rcg_pkg::sq_beat_t out_beat
);

    import rcg_pkg::*;

    logic     valid_reg;
    sq_beat_t beat_reg;
    sq_beat_t beat_next;

    always_comb
    begin
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        beat_next       = in_beat;
        for (int k = 0; k < CH_N; k++)
        begin
            acc   = {in_beat.lane[k].rem, in_beat.lane[k].rad[RAD_W-1 -: 2]};
            trial = (REM_W+2)'({in_beat.lane[k].root, 2'b01});
            beat_next.lane[k].rad = {in_beat.lane[k].rad[RAD_W-3:0], 2'b00};
            if (acc >= trial)
            begin
                beat_next.lane[k].rem  = REM_W'(acc - trial);
                beat_next.lane[k].root = {in_beat.lane[k].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                beat_next.lane[k].rem  = REM_W'(acc);
                beat_next.lane[k].root = {in_beat.lane[k].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

@@ sv/roberts_cross_gradient.sv @@
// ----------------------------------------------------------------------------
// roberts_cross_gradient: roberts cross edge magnitude on a pixel stream
// one line buffer, diff and square stages, a chain of square root cells
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              beat
//  pix       in   pix_valid/pix_ready    frame_start, chan0..chan2
//  grad      out  grad_valid/grad_ready  grad0..grad2
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  one pixel beat per clock sustained while grad_ready holds; a result passes
//  the line buffer read, diff, square, one cell per root digit and the output
//  every stage has its own valid, so bubbles collapse and ready only drops
//  when the stage behind the line buffer read is full and blocked
//  reset clears control state and the neighbor registers; line buffer contents
//  are undefined until written and there is no clearing pass
//  cfg_ready is always high
//
module roberts_cross_gradient (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  rcg_pkg::pix_beat_t            pix,
    output logic                          grad_valid,
    input  logic                          grad_ready,
    output rcg_pkg::grad_beat_t           grad,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcg_pkg::CFG_W-1:0]     cfg_data
);

    import rcg_pkg::*;

    // config registers
    logic            color_mode_reg;
    logic [LW_W-1:0] line_width_reg;

    // raster position
    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic              past_reg;
    logic              past_next;
    logic [ADDR_W-1:0] col_use;
    logic [CMP_W-1:0]  width_eff;
    logic [CMP_W-1:0]  col_inc;
    logic              pix_fire;
    logic              emit;

    // stage 1: pixel waiting for its line buffer read
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_color_reg;
    logic [PIX_W-1:0] s1_cur_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] upleft_reg;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] cur_pix;
    logic             s1_leave;

    // stage 2: absolute differences
    logic                           s2_valid_reg;
    logic                           s2_ready;
    logic                           s2_color_reg;
    logic [CH_N-1:0][CH_W-1:0]      s2_abs1_reg;
    logic [CH_N-1:0][CH_W-1:0]      s2_abs2_reg;
    logic [CH_N-1:0][CH_W-1:0]      abs1;
    logic [CH_N-1:0][CH_W-1:0]      abs2;

    // stage 3: sums of squares
    logic                           s3_valid_reg;
    logic                           s3_ready;
    logic                           s3_color_reg;
    logic [CH_N-1:0][SUM_W-1:0]     s3_sum_reg;

    // root cell chain
    logic     [ROOT_W:0] chain_valid;
    logic     [ROOT_W:0] chain_ready;
    sq_beat_t            chain_head;
    sq_beat_t            chain_beat [ROOT_W+1];

    // output register
    logic       out_valid_reg;
    grad_beat_t out_reg;
    grad_beat_t out_next;

    // ---- config port ----
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            line_width_reg <= LW_W'(640);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[LW_W-1:0];
                default:        color_mode_reg <= color_mode_reg;
            endcase
        end
    end

    // ---- raster counter ----
    assign pix_fire = pix_valid && pix_ready;
    assign col_use  = pix.frame_start ? '0 : col_reg;
    assign emit     = !pix.frame_start && past_reg && (col_use != '0);

    // clamp line width to the line buffer size, at least two pixels
    always_comb
    begin
        if (CMP_W'(line_width_reg) < CMP_W'(2))
            width_eff = CMP_W'(2);
        else if (CMP_W'(line_width_reg) > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = CMP_W'(line_width_reg);
    end

    // wrap at end of row, first wrap marks a full row in the buffer
    always_comb
    begin
        col_inc   = CMP_W'(col_use) + CMP_W'(1);
        past_next = pix.frame_start ? 1'b0 : past_reg;
        col_next  = col_inc[ADDR_W-1:0];
        if (col_inc >= width_eff)
        begin
            col_next  = '0;
            past_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            past_reg <= 1'b0;
        end
        else if (pix_fire)
        begin
            col_reg  <= col_next;
            past_reg <= past_next;
        end
    end

    // ---- line buffer: read old row entry, write current pixel, same beat ----
    assign cur_pix = {pix.chan2, pix.chan1, pix.chan0};

    rcg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (pix_fire),
        .waddr (col_use),
        .wdata (cur_pix),
        .re    (pix_fire),
        .raddr (col_use),
        .rdata (above)
    );

    // ---- stage 1 ----
    assign s1_leave  = s1_valid_reg && s2_ready;
    assign pix_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            left_reg     <= '0;
            upleft_reg   <= '0;
        end
        else
        begin
            if (pix_ready)
            begin
                s1_valid_reg <= pix_valid;
                s1_emit_reg  <= pix_valid && emit;
            end
            // neighbors for the next pixel, taken as this one moves on
            if (s1_leave)
            begin
                left_reg   <= s1_cur_reg;
                upleft_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_cur_reg   <= cur_pix;
            s1_color_reg <= color_mode_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < CH_N; k++)
        begin
            abs1[k] = abs_diff(upleft_reg[k*CH_W +: CH_W], s1_cur_reg[k*CH_W +: CH_W]);
            abs2[k] = abs_diff(left_reg[k*CH_W +: CH_W], above[k*CH_W +: CH_W]);
        end
    end

    // ---- stage 2 ----
    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            s2_abs1_reg  <= abs1;
            s2_abs2_reg  <= abs2;
            s2_color_reg <= s1_color_reg;
        end
    end

    // ---- stage 3 ----
    assign s3_ready = !s3_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            for (int k = 0; k < CH_N; k++)
            begin
                s3_sum_reg[k] <= SUM_W'(s2_abs1_reg[k]) * SUM_W'(s2_abs1_reg[k])
                               + SUM_W'(s2_abs2_reg[k]) * SUM_W'(s2_abs2_reg[k]);
            end
            s3_color_reg <= s2_color_reg;
        end
    end

    // ---- root chain: one cell per root digit, msb first ----
    assign chain_valid[0] = s3_valid_reg;

    always_comb
    begin
        chain_head.color = s3_color_reg;
        for (int k = 0; k < CH_N; k++)
        begin
            chain_head.lane[k].rad  = RAD_W'(s3_sum_reg[k]);
            chain_head.lane[k].rem  = '0;
            chain_head.lane[k].root = '0;
        end
    end

    assign chain_beat[0] = chain_head;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        rcg_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_beat   (chain_beat[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_beat  (chain_beat[i+1])
        );
    end

    assign chain_ready[ROOT_W] = !out_valid_reg || grad_ready;

    // ---- rounding, saturation, grayscale zeroing ----
    always_comb
    begin
        logic [REM_W-1:0]  rootx;
        logic [GRAD_W-1:0] g [CH_N];
        for (int k = 0; k < CH_N; k++)
        begin
            rootx = REM_W'(chain_beat[ROOT_W].lane[k].root);
            // color mode rounds: remainder above root means past the half
            if (chain_beat[ROOT_W].color && (chain_beat[ROOT_W].lane[k].rem > rootx))
                rootx = rootx + REM_W'(1);
            if (rootx > REM_W'(255))
                g[k] = GRAD_W'(255);
            else
                g[k] = rootx[GRAD_W-1:0];
            if (k != 0 && !chain_beat[ROOT_W].color)
                g[k] = '0;
        end
        out_next.grad0 = g[0];
        out_next.grad1 = g[1];
        out_next.grad2 = g[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (chain_ready[ROOT_W])
        begin
            out_valid_reg <= chain_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[ROOT_W] && chain_ready[ROOT_W])
        begin
            out_reg <= out_next;
        end
    end

    assign grad_valid = out_valid_reg;
    assign grad       = out_reg;

    // ---- assertions ----
    // a new frame never gives a result on its first pixel
    a_frame_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && pix.frame_start |=> !s1_emit_reg)
        else $error("result emitted on frame start");

    // column zero never gives a result
    a_col0_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && (col_use == '0) |=> !s1_emit_reg)
        else $error("result emitted on column zero");

    // line buffer read data must hold while stage 1 is blocked
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |-> !pix_ready)
        else $error("pixel taken while line buffer read is pending");

    // first full row is marked only by an accepted pixel
    a_past_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(past_reg) |-> $past(pix_fire))
        else $error("row flag set without a pixel");

endmodule

@@ tb/tb_roberts_cross_gradient.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_roberts_cross_gradient: self-checking bench for the roberts cross block
// a directed table of pixel beats and register writes, then random phases
// over widths and modes; every gradient beat is checked against a written value or the predictor
// ----------------------------------------------------------------------------
module tb_roberts_cross_gradient;
    import rcg_pkg::*;

    localparam int DRAIN_CYC = 32;      // block latency plus margin
    localparam int LIMIT_CYC = 200000;  // watchdog
    localparam int HOLD_CYC  = 200;     // long receiver hold-off
    localparam int N_PH      = 9;

    // directed table row: a pixel beat or a register setting
    typedef enum bit {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        bit                mode;
        logic [LW_W-1:0]   width;
        pix_beat_t         p;
        bit                typed;   // expected gradient written in the row
        grad_beat_t        want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_ready;
    pix_beat_t            pix;
    logic                 grad_valid;
    logic                 grad_ready;
    grad_beat_t           grad;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state, mirrors the block's line buffer and counters
    logic [PIX_W-1:0] line_buf_m [MAX_WIDTH];
    logic [PIX_W-1:0] left_m   = '0;
    logic [PIX_W-1:0] upleft_m = '0;
    int               col_m      = 0;
    bit               row_seen_m = 0;
    bit               mode_m     = 0;
    logic [LW_W-1:0]  width_m    = 12'd640;

    // gradients still owed by the block, oldest first
    grad_beat_t grad_due [$];
    dir_row_t   dir_tab [$];

    logic [7:0] tone [3];       // slowly moving level for near-flat pixels
    int send_idle  = 23;
    int recv_idle  = 46;
    bit hold_req   = 0;
    int n_pix      = 0;
    int n_res      = 0;
    int n_cfg      = 0;
    int err_cnt    = 0;
    int cycles     = 0;
    int stall_cyc  = 0;

    roberts_cross_gradient dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .grad_valid (grad_valid),
        .grad_ready (grad_ready),
        .grad       (grad),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one channel of the cross magnitude: floor root, optional rounding, clamp
    function automatic logic [7:0] cross_mag(input logic [7:0] ul, input logic [7:0] cur,
                                             input logic [7:0] lf, input logic [7:0] up,
                                             input bit rnd);
        int d1;
        int d2;
        int s;
        int r;
        d1 = int'(ul) - int'(cur);
        d2 = int'(lf) - int'(up);
        s  = d1 * d1 + d2 * d2;
        r  = 0;
        while ((r + 1) * (r + 1) <= s)
            r++;
        // halves cannot occur, so above r*r+r means nearer to r+1
        if (rnd && s > r * r + r)
            r++;
        if (r > 255)
            r = 255;
        return r[7:0];
    endfunction

    // advance the predictor by one accepted pixel beat
    function automatic void roberts_predict(input pix_beat_t p, output bit hit,
                                            output grad_beat_t g);
        int               w;
        int               col;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] above;
        // out-of-range widths clamp to 2 and to the buffer depth
        w = int'(width_m);
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (p.frame_start)
        begin
            col_m      = 0;
            row_seen_m = 0;
        end
        col = col_m;
        if (col >= MAX_WIDTH)
            col = 0;
        cur   = {p.chan2, p.chan1, p.chan0};
        above = line_buf_m[col];
        hit   = row_seen_m && col >= 1;
        g     = '0;
        if (hit)
        begin
            g.grad0 = cross_mag(upleft_m[7:0], cur[7:0], left_m[7:0], above[7:0], mode_m);
            if (mode_m)
            begin
                g.grad1 = cross_mag(upleft_m[15:8], cur[15:8], left_m[15:8],
                                    above[15:8], 1'b1);
                g.grad2 = cross_mag(upleft_m[23:16], cur[23:16], left_m[23:16],
                                    above[23:16], 1'b1);
            end
        end
        upleft_m        = above;
        left_m          = cur;
        line_buf_m[col] = cur;
        col++;
        // wrap on the current width, even if it shrank mid-line
        if (col >= w)
        begin
            col        = 0;
            row_seen_m = 1;
        end
        col_m = col;
    endfunction

    // random pixel: mix of full range, rails and small steps around a level
    function automatic pix_beat_t rand_pixel(input bit fs);
        pix_beat_t  p;
        logic [7:0] v [3];
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 3))
                0: v[k] = 8'($urandom_range(0, 255));
                1: v[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                        tone[k] = 8'($urandom_range(0, 255));
                    v[k] = tone[k] + 8'($urandom_range(0, 6)) - 8'd3;
                end
            endcase
        end
        p.frame_start = fs;
        p.chan0       = v[0];
        p.chan1       = v[1];
        p.chan2       = v[2];
        return p;
    endfunction

    function automatic dir_row_t pix_row(input bit fs, input logic [7:0] c0,
                                         input logic [7:0] c1, input logic [7:0] c2,
                                         input bit typed, input logic [23:0] want);
        dir_row_t r;
        r.kind          = ROW_PIX;
        r.mode          = 1'b0;
        r.width         = '0;
        r.p.frame_start = fs;
        r.p.chan0       = c0;
        r.p.chan1       = c1;
        r.p.chan2       = c2;
        r.typed         = typed;
        r.want          = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input bit mode, input logic [LW_W-1:0] width);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.mode  = mode;
        r.width = width;
        r.p     = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // append one row at the end of the directed table
    function automatic void add_row(input dir_row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    // offer one pixel beat after a random gap; valid stays high afterwards so a
    // following beat with no gap goes out back to back without a drop
    task automatic send_pixel(input pix_beat_t p, input bit typed, input grad_beat_t want);
        bit         hit;
        grad_beat_t g;
        while ($urandom_range(0, 99) < send_idle)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        roberts_predict(p, hit, g);
        if (hit)
            grad_due.insert(grad_due.size(), typed ? want : g);
        n_pix++;
    endtask

    // let the block run dry; beats with no result may still be in flight after
    // the last gradient, so wait out the pipeline too
    task automatic wait_quiet();
        pix_valid <= 1'b0;
        while (grad_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // write both registers back to back once the block is idle
    task automatic reconfigure(input bit mode, input logic [LW_W-1:0] width);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COLOR_MODE;
        cfg_data  <= CFG_W'(mode);
        do
            @(posedge clk);
        while (!cfg_ready);
        mode_m     = mode;
        cfg_index <= CFG_LINE_WIDTH;
        cfg_data  <= width;
        do
            @(posedge clk);
        while (!cfg_ready);
        width_m    = width;
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // gradient side: random ready, one long hold-off on request, checks
    initial
    begin
        int hold_cnt;
        hold_cnt   = 0;
        grad_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (grad_valid && grad_ready)
            begin
                if (grad_due.size() == 0)
                begin
                    $display("%0t: gradient beat with none expected: %h", $time, grad);
                    err_cnt++;
                end
                else
                begin
                    grad_beat_t exp_g;
                    exp_g = grad_due.pop_front();
                    if (grad.grad0 !== exp_g.grad0)
                    begin
                        $display("%0t: grad0 expected %0d got %0d",
                                 $time, exp_g.grad0, grad.grad0);
                        err_cnt++;
                    end
                    if (grad.grad1 !== exp_g.grad1)
                    begin
                        $display("%0t: grad1 expected %0d got %0d",
                                 $time, exp_g.grad1, grad.grad1);
                        err_cnt++;
                    end
                    if (grad.grad2 !== exp_g.grad2)
                    begin
                        $display("%0t: grad2 expected %0d got %0d",
                                 $time, exp_g.grad2, grad.grad2);
                        err_cnt++;
                    end
                    n_res++;
                end
            end
            // long hold-off so the pipeline fills and stalls the pixel side
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                grad_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req    = 0;
                hold_cnt    = HOLD_CYC;
                grad_ready <= 1'b0;
            end
            else
                grad_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog, also counts cycles where the block refused a pixel
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (pix_valid && !pix_ready)
                stall_cyc++;
            if (cycles > LIMIT_CYC)
            begin
                $display("%0t: timeout, %0d gradients still owed", $time, grad_due.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // random phases: color mode, width register value, pixel beats
    int ph_mode  [N_PH] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
    int ph_width [N_PH] = '{5, 16, 0, 7, 4095, 2, 33, 3, 12};
    int ph_items [N_PH] = '{80, 100, 60, 80, 100, 60, 100, 60, 90};

    initial
    begin
        bit fs;
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLOR_MODE;
        cfg_data  = '0;
        foreach (line_buf_m[j])
            line_buf_m[j] = '0;
        foreach (tone[j])
            tone[j] = 8'($urandom_range(0, 255));

        // width 1 behaves as 2: one result per row after the first
        add_row(cfg_row(1'b0, 12'd1));
        add_row(pix_row(1'b1, 8'd255, 8'h12, 8'h34, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd0,   8'hab, 8'hcd, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd255, 8'hff, 8'h00, 1'b0, 24'h0));
        // both diagonals at full swing: grayscale clamps, other channels zero
        add_row(pix_row(1'b0, 8'd0,   8'h01, 8'h80, 1'b1, 24'hff_00_00));
        add_row(pix_row(1'b0, 8'd0,   8'h5a, 8'ha5, 1'b0, 24'h0));
        // flat diagonals give zero
        add_row(pix_row(1'b0, 8'd255, 8'h00, 8'hff, 1'b1, 24'h00_00_00));
        add_row(pix_row(1'b0, 8'd100, 8'h33, 8'hcc, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd0,   8'hf0, 8'h0f, 1'b0, 24'h0));
        // mode switch in the middle of a frame, no frame start
        add_row(cfg_row(1'b1, 12'd1));
        add_row(pix_row(1'b0, 8'd0,   8'd255, 8'd7,   1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd255, 8'd0,   8'd200, 1'b0, 24'h0));
        // color clamp on all three channels
        add_row(pix_row(1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd0,   8'd0,   8'd0,   1'b1, 24'hff_ff_ff));
        // width 4 frame, then shrink to 2 in the middle of the second row
        add_row(cfg_row(1'b1, 12'd4));
        add_row(pix_row(1'b1, 8'd10, 8'd20, 8'd30, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd11, 8'd22, 8'd33, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd12, 8'd24, 8'd36, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd13, 8'd26, 8'd39, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd9,  8'd19, 8'd29, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd12, 8'd21, 8'd31, 1'b0, 24'h0));
        add_row(cfg_row(1'b1, 12'd2));
        add_row(pix_row(1'b0, 8'd0,   8'd128, 8'd255, 1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd200, 8'd100, 8'd50,  1'b0, 24'h0));
        add_row(pix_row(1'b0, 8'd7,   8'd8,   8'd9,   1'b0, 24'h0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender and receiver both idling at random
        foreach (dir_tab[j])
        begin
            if (dir_tab[j].kind == ROW_CFG)
                reconfigure(dir_tab[j].mode, dir_tab[j].width);
            else
                send_pixel(dir_tab[j].p, dir_tab[j].typed, dir_tab[j].want);
        end

        // random phases; idling regime changes every three phases
        for (int ph = 0; ph < N_PH; ph++)
        begin
            case (ph / 3)
                0:
                begin
                    send_idle = 23;
                    recv_idle = 46;
                end
                1:
                begin
                    send_idle = 46;
                    recv_idle = 23;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            reconfigure(ph_mode[ph][0], LW_W'(ph_width[ph]));
            if (ph == 1)
                hold_req = 1;
            for (int i = 0; i < ph_items[ph]; i++)
            begin
                // every phase opens a frame; phases shorter than the buffer depth also get stray restarts
                fs = (i == 0) || (ph_items[ph] < MAX_WIDTH && $urandom_range(0, 49) == 0);
                send_pixel(rand_pixel(fs), 1'b0, '0);
            end
        end

        wait_quiet();
        $display("%0d pixel beats sent, %0d gradient beats checked, %0d register settings",
                 n_pix, n_res, n_cfg);
        $display("widths 2 to 33 plus an oversized setting, both modes, clamping, %s%0d %s",
                 "mid-line width change, ", stall_cyc, "cycles of input backpressure");
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ roberts_cross_gradient.f @@
sv/rcg_pkg.sv
sv/rcg_ram.sv
sv/rcg_sqrt_cell.sv
sv/roberts_cross_gradient.sv
tb/tb_roberts_cross_gradient.sv
